FILE: src/assert_macros.svh
// Assertion macros used by thermal_plant_model_step.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge outside reset.
`define TPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property at every rising edge, reset included.
`define TPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tpm_pkg.sv
package tpm_pkg;

   localparam int DATA_W       = 32;
   localparam int FRAC_BITS    = 16;
   localparam int Q_W          = DATA_W + FRAC_BITS;
   localparam int TERM_W       = 2 * DATA_W + 1;
   localparam int ACC_W        = TERM_W + 1;
   localparam int CSR_IDX_W    = 3;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_W     = 33;
   localparam int SINE_SHIFT   = 30 - FRAC_BITS;

   localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
   localparam logic [5:0] SHORT_LAST  = 6'(DATA_W - 1);
   localparam logic [5:0] LONG_LAST   = 6'(Q_W - 1);

   localparam logic signed [DATA_W-1:0]   TURN_PER_RAD = 32'sd683565276;
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 33'sd652032874;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_D = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT   = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PHASE,
      ST_MUL_A,
      ST_MUL_PP,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_D,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic long_op;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [29:0] atan_turns(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:    r = 30'd536870912;
         5'd1:    r = 30'd316933406;
         5'd2:    r = 30'd167458907;
         5'd3:    r = 30'd85004756;
         5'd4:    r = 30'd42667331;
         5'd5:    r = 30'd21354465;
         5'd6:    r = 30'd10679838;
         5'd7:    r = 30'd5340245;
         5'd8:    r = 30'd2670163;
         5'd9:    r = 30'd1335087;
         5'd10:   r = 30'd667544;
         5'd11:   r = 30'd333772;
         5'd12:   r = 30'd166886;
         5'd13:   r = 30'd83443;
         5'd14:   r = 30'd41722;
         5'd15:   r = 30'd20861;
         5'd16:   r = 30'd10430;
         5'd17:   r = 30'd5215;
         5'd18:   r = 30'd2608;
         5'd19:   r = 30'd1304;
         5'd20:   r = 30'd652;
         5'd21:   r = 30'd326;
         5'd22:   r = 30'd163;
         5'd23:   r = 30'd81;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: src/tpm_mul.sv
module tpm_mul
   import tpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mul_ctl_type              ctl,
   input  logic signed [DATA_W-1:0] multiplicand,
   input  logic [Q_W-1:0]           multiplier,
   output mul_stat_type             stat,
   output logic signed [TERM_W-1:0] term
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       long_ff, long_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic signed [DATA_W:0]     high_ff, high_in;
   logic [Q_W-1:0]             q_ff, q_in;
   logic signed [DATA_W-1:0]   m_ff, m_in;
   logic                       last;
   logic signed [DATA_W+1:0]   addend;
   logic signed [DATA_W+1:0]   sum;

   // One multiplier bit per cycle; the sign bit weighs negative.
   always_comb begin
      last   = (cnt_ff == (long_ff ? LONG_LAST : SHORT_LAST));
      addend = '0;
      if (q_ff[0]) begin
         addend = last ? -{{2{m_ff[DATA_W-1]}}, m_ff} : {{2{m_ff[DATA_W-1]}}, m_ff};
      end
      sum = {high_ff[DATA_W], high_ff} + addend;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      long_in = long_ff;
      cnt_in  = cnt_ff;
      high_in = high_ff;
      q_in    = q_ff;
      m_in    = m_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         long_in = ctl.long_op;
         cnt_in  = '0;
         high_in = '0;
         q_in    = multiplier;
         m_in    = multiplicand;
      end else if (busy_ff) begin
         high_in = sum[DATA_W+1:1];
         q_in    = {sum[0], q_ff[Q_W-1:1]};
         cnt_in  = cnt_ff + 6'd1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      long_ff <= long_in;
      cnt_ff  <= cnt_in;
      high_ff <= high_in;
      q_ff    <= q_in;
      m_ff    <= m_in;
   end

   // Product shifted right by the fraction bits, rounded toward minus infinity.
   always_comb begin
      if (long_ff) begin
         term = {high_ff, q_ff[Q_W-1:FRAC_BITS]};
      end else begin
         term = {{FRAC_BITS{high_ff[DATA_W]}}, high_ff, q_ff[Q_W-1:Q_W-FRAC_BITS]};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: src/tpm_cordic.sv
module tpm_cordic
   import tpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DATA_W-1:0]        phase,
   output logic                     sine_ready,
   output logic signed [DATA_W-1:0] sine
);

   logic                       busy_ff, busy_in;
   logic                       valid_ff, valid_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   logic [DATA_W-1:0]          folded;
   logic signed [CORDIC_W-1:0] dx, dy, da, ysh;

   always_comb begin
      folded = phase;
      if (phase inside {[32'h4000_0000 : 32'hBFFF_FFFF]}) begin
         folded = 32'h8000_0000 - phase;
      end
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      da = $signed({3'b000, atan_turns(cnt_ff)});
   end

   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      if (start) begin
         busy_in  = 1'b1;
         valid_in = 1'b0;
         cnt_in   = '0;
         x_in     = CORDIC_START;
         y_in     = '0;
         z_in     = $signed({folded[DATA_W-1], folded});
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - da;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + da;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == CORDIC_LAST) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign ysh        = y_ff >>> SINE_SHIFT;
   assign sine       = ysh[DATA_W-1:0];
   assign sine_ready = valid_ff;

endmodule

FILE: src/thermal_plant_model_step.sv
// Discrete thermal plant, one time step per request transfer.
// The req channel carries the warming input and a restart flag; the rsp
// channel returns the new temperature and an overflow flag, both with
// valid and ready. Coefficients, mode and initial temperature are written
// through the csr port; the user must write them only while the block is
// idle, as the block itself does not enforce this. All products run
// through one shift-add multiplier that retires one multiplier bit per
// cycle, with a 48-bit multiplier for the product of the squared term.
// A linear step runs two products; a nonlinear step runs the phase and
// then five products (the 24-step CORDIC sine overlaps them). One step
// is in flight at a time, so a new request is taken only once the
// previous step has finished.
// A finished result waits in the output register while the next request
// is already taken; if the receiver stalls, that next step holds at its
// end until the register frees.
// Reset clears the configuration, both temperatures and the output valid.
`include "assert_macros.svh"

module thermal_plant_model_step
   import tpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_warming,
   input  logic                     req_restart,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_temperature,
   output logic                     rsp_overflow,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_write_data
);

   state_type                  state_ff, state_in;
   logic                       mode_ff;
   logic signed [DATA_W-1:0]   coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff, init_ff;
   logic signed [DATA_W-1:0]   cur_ff, prev_ff, u_ff;
   logic [Q_W-1:0]             sq_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic                       issued_ff;
   logic                       rsp_valid_ff;
   logic signed [DATA_W-1:0]   rsp_temp_ff;
   logic                       rsp_ovf_ff;

   mul_ctl_type                mul_ctl;
   mul_stat_type               mul_stat;
   logic signed [DATA_W-1:0]   mul_m;
   logic [Q_W-1:0]             mul_q;
   logic signed [TERM_W-1:0]   term;
   logic signed [ACC_W-1:0]    term_x;
   logic                       cordic_start;
   logic                       sin_ready;
   logic signed [DATA_W-1:0]   sine;
   logic                       is_mul;
   logic                       out_free;
   logic                       sat_hi, sat_lo;
   logic signed [DATA_W-1:0]   result;

   tpm_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .ctl          (mul_ctl),
      .multiplicand (mul_m),
      .multiplier   (mul_q),
      .stat         (mul_stat),
      .term         (term)
   );

   tpm_cordic u_cordic (
      .clock      (clock),
      .reset      (reset),
      .start      (cordic_start),
      .phase      (term[DATA_W-1:0]),
      .sine_ready (sin_ready),
      .sine       (sine)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign term_x   = {term[TERM_W-1], term};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = mode_ff ? ST_PHASE : ST_MUL_A;
         ST_PHASE:  if (mul_stat.done) state_in = ST_MUL_A;
         ST_MUL_A:  if (mul_stat.done) state_in = mode_ff ? ST_MUL_PP : ST_MUL_B;
         ST_MUL_PP: if (mul_stat.done) state_in = ST_MUL_B;
         ST_MUL_B:  if (mul_stat.done) state_in = mode_ff ? ST_MUL_C : ST_FINISH;
         ST_MUL_C:  if (mul_stat.done) state_in = ST_MUL_D;
         ST_MUL_D:  if (mul_stat.done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      is_mul           = (state_ff inside {ST_PHASE, ST_MUL_A, ST_MUL_PP, ST_MUL_B,
                                           ST_MUL_C, ST_MUL_D});
      mul_ctl.start    = is_mul && !issued_ff && (state_ff != ST_MUL_D || sin_ready);
      mul_ctl.long_op  = (state_ff == ST_MUL_B) && mode_ff;
      cordic_start     = (state_ff == ST_PHASE) && mul_stat.done;
      mul_m            = coef_a_ff;
      mul_q            = {{(Q_W-DATA_W){1'b0}}, u_ff};
      case (state_ff)
         ST_PHASE: begin
            mul_m = TURN_PER_RAD;
         end
         ST_MUL_A: begin
            mul_q = {{(Q_W-DATA_W){1'b0}}, cur_ff};
         end
         ST_MUL_PP: begin
            mul_m = prev_ff;
            mul_q = {{(Q_W-DATA_W){1'b0}}, prev_ff};
         end
         ST_MUL_B: begin
            mul_m = coef_b_ff;
            if (mode_ff) begin
               mul_q = sq_ff;
            end
         end
         ST_MUL_C: begin
            mul_m = coef_c_ff;
         end
         ST_MUL_D: begin
            mul_m = coef_d_ff;
            mul_q = {{(Q_W-DATA_W){1'b0}}, sine};
         end
         default: begin
            mul_m = coef_a_ff;
         end
      endcase
   end

   always_comb begin
      sat_hi = !acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:DATA_W-1] != '0);
      sat_lo = acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:DATA_W-1] != '1);
      result = acc_ff[DATA_W-1:0];
      if (sat_hi) begin
         result = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sat_lo) begin
         result = {1'b1, {(DATA_W-1){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         coef_a_ff    <= '0;
         coef_b_ff    <= '0;
         coef_c_ff    <= '0;
         coef_d_ff    <= '0;
         init_ff      <= '0;
         cur_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (mul_ctl.start) begin
            issued_ff <= 1'b1;
         end else if (mul_stat.done) begin
            issued_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MODE:   mode_ff   <= csr_write_data[0];
               CSR_COEF_A: coef_a_ff <= csr_write_data;
               CSR_COEF_B: coef_b_ff <= csr_write_data;
               CSR_COEF_C: coef_c_ff <= csr_write_data;
               CSR_COEF_D: coef_d_ff <= csr_write_data;
               CSR_INIT:   init_ff   <= csr_write_data;
               default:    ;
            endcase
         end
         if (req_valid && req_ready && req_restart) begin
            cur_ff  <= init_ff;
            prev_ff <= '0;
         end
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
            prev_ff      <= cur_ff;
            cur_ff       <= result;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         u_ff <= req_warming;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_temp_ff <= result;
         rsp_ovf_ff  <= sat_hi || sat_lo;
      end
      if (mul_stat.done) begin
         case (state_ff)
            ST_MUL_A:  acc_ff <= term_x;
            ST_MUL_PP: sq_ff  <= term[Q_W-1:0];
            ST_MUL_B:  acc_ff <= mode_ff ? acc_ff - term_x : acc_ff + term_x;
            ST_MUL_C:  acc_ff <= acc_ff + term_x;
            ST_MUL_D:  acc_ff <= acc_ff + term_x;
            default:   ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   `TPM_ASSERT(a_accept_leaves_idle, clock, reset, (req_valid && req_ready) |=> (state_ff != ST_IDLE), "accepted request did not start a step")
   `TPM_ASSERT(a_idle_mul_free, clock, reset, req_ready |-> !mul_stat.busy, "multiplier busy while idle")
   `TPM_ASSERT(a_phase_nonlinear, clock, reset, (state_ff == ST_PHASE) |-> mode_ff, "sine phase computed in linear mode")
   `TPM_ASSERT(a_ovf_at_limit, clock, reset, (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_temp_ff == {1'b0, {(DATA_W-1){1'b1}}} || rsp_temp_ff == {1'b1, {(DATA_W-1){1'b0}}}), "overflow flag without saturated temperature")

endmodule
